// ----- sv/vollath_f4_focus_measure_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Vollath F4 focus measure checker
// ----------------------------------------------------------------------------
`ifndef VOLLATH_F4_FOCUS_MEASURE_ASSERT_SVH
`define VOLLATH_F4_FOCUS_MEASURE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define VFF_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("vff check failed");

// Next-cycle implication, disabled while reset is asserted
`define VFF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("vff check failed");

// Next-cycle implication that also covers the reset cycles
`define VFF_ASSERT_RESET(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("vff reset check failed");

`endif

// ----- sv/vff_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vff_pkg
// Shared types and constants of the Vollath F4 focus measure.
// ----------------------------------------------------------------------------
package vff_pkg;

    localparam int PIX_W       = 8;
    localparam int PROD_W      = 2 * PIX_W;
    localparam int SUM_W       = 37;
    localparam int CFG_W       = 11;
    localparam int CFG_INDEX_W = 1;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_REGION_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_REGION_HEIGHT = 1'b1;

    // Register values after reset
    localparam logic [CFG_W-1:0] RESET_REGION_WIDTH  = 11'd16;
    localparam logic [CFG_W-1:0] RESET_REGION_HEIGHT = 11'd480;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // One line store entry: the pixel one row above and two rows above
    typedef struct packed {
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] two_above;
    } line_pair_t;

endpackage

// ----- sv/vff_line_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vff_line_store
// Dual line store in one synchronous memory: each entry holds the pixels of
// the previous row and the row before it for one column. One read and one
// write per cycle, registered read data, forwarding of a same-edge write.
// ----------------------------------------------------------------------------
module vff_line_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                 aclk,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output vff_pkg::line_pair_t  rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  vff_pkg::line_pair_t  wr_data
);

    vff_pkg::line_pair_t mem [DEPTH];
    vff_pkg::line_pair_t rd_data_reg;
    vff_pkg::line_pair_t fwd_data_reg;
    logic                fwd_hit_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; capture a write to the same entry on the same edge
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

endmodule

// ----- sv/vollath_f4_focus_measure.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vollath_f4_focus_measure
// Vollath F4 autocorrelation focus measure over a raster region of pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_ channel (valid/ready), row by row, one word per
//   clock while s_ready is high. Region size is set on the cfg_ write port
//   (region width, region height) while the block is idle; reset loads 16 x 480.
//   After the last pixel of a region one word leaves on the m_ channel: the
//   lag-one product sum minus the lag-two product sum, saturated to 37 bits
//   signed. Counters and sums then clear for the next region.
//   The last pixel passes the stage 1, 2 and 3 registers into the result queue.
//   Throughput: one pixel per clock while s_ready is high, bounded by the single
//   read-modify-write of the line store memory per pixel (a read at accept, a
//   write in the cycle after, with forwarding when both hit the same column).
//   A stalled receiver fills a 4-word result queue; s_ready drops only when
//   queued and in-flight results could overflow it, so pixels keep flowing
//   while a result waits.
//   Reset (aresetn low, synchronous) clears positions, sums, the pipeline
//   and the queue; line store contents are left as they are.
// ----------------------------------------------------------------------------
module vollath_f4_focus_measure #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // pixel input
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [vff_pkg::PIX_W-1:0]              s_pixel,
    // result output
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [vff_pkg::SUM_W-1:0]       m_focus_measure,
    // configuration writes
    input  logic                                   cfg_wr_en,
    input  logic [vff_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [vff_pkg::CFG_W-1:0]              cfg_wr_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_W = ($clog2(MAX_DIM + 1) > vff_pkg::CFG_W) ?
                           $clog2(MAX_DIM + 1) : vff_pkg::CFG_W;
    localparam int CMP_W = DIM_W + 1;
    localparam int PW    = vff_pkg::PROD_W;
    localparam int SW    = vff_pkg::SUM_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [vff_pkg::CFG_W-1:0] width_reg;
    logic [vff_pkg::CFG_W-1:0] height_reg;

    // Decode register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= vff_pkg::RESET_REGION_WIDTH;
            height_reg <= vff_pkg::RESET_REGION_HEIGHT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                vff_pkg::REG_REGION_WIDTH:  width_reg  <= cfg_wr_data;
                vff_pkg::REG_REGION_HEIGHT: height_reg <= cfg_wr_data;
            endcase
        end
    end

    // Clamp sizes: zero acts as one, oversize acts as the maximum
    logic [CMP_W-1:0] w_raw;
    logic [CMP_W-1:0] h_raw;
    logic [CMP_W-1:0] w_eff;
    logic [CMP_W-1:0] h_eff;

    always_comb begin
        w_raw = CMP_W'(width_reg);
        h_raw = CMP_W'(height_reg);
        if (w_raw == '0) begin
            w_eff = CMP_W'(1);
        end else if (w_raw > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
        if (h_raw == '0) begin
            h_eff = CMP_W'(1);
        end else if (h_raw > CMP_W'(MAX_HEIGHT)) begin
            h_eff = CMP_W'(MAX_HEIGHT);
        end else begin
            h_eff = h_raw;
        end
    end

    // ------------------------------------------------------------------
    // Position counters
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;
    logic             s_accept;
    logic             row_done;
    logic             region_done;
    logic             use_lag_one;
    logic             use_lag_two;

    assign s_accept    = s_valid && s_ready;
    assign row_done    = (CMP_W'(col_reg) + CMP_W'(1)) >= w_eff;
    assign region_done = row_done && ((CMP_W'(row_reg) + CMP_W'(1)) >= h_eff);
    assign use_lag_one = (row_reg != '0);
    assign use_lag_two = (row_reg[ROW_W-1:1] != '0);

    // Advance column and row, wrap at row and region end
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_accept) begin
            if (row_done) begin
                col_next = '0;
                if (region_done) begin
                    row_next = '0;
                end else begin
                    row_next = row_reg + ROW_W'(1);
                end
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line store read returns, write back shifted column
    // ------------------------------------------------------------------
    logic                          s1_valid_reg;
    logic [COL_W-1:0]              s1_addr_reg;
    logic [vff_pkg::PIX_W-1:0]     s1_pixel_reg;
    logic                          s1_use1_reg;
    logic                          s1_use2_reg;
    logic                          s1_last_reg;
    vff_pkg::line_pair_t           ls_rd_data;
    vff_pkg::line_pair_t           ls_wr_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_addr_reg  <= col_reg;
            s1_pixel_reg <= s_pixel;
            s1_use1_reg  <= use_lag_one;
            s1_use2_reg  <= use_lag_two;
            s1_last_reg  <= region_done;
        end
    end

    // Shift the column down one row: new pixel on top
    always_comb begin
        ls_wr_data.above     = s1_pixel_reg;
        ls_wr_data.two_above = ls_rd_data.above;
    end

    vff_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (col_reg),
        .rd_data (ls_rd_data),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (ls_wr_data)
    );

    // ------------------------------------------------------------------
    // Stage 2: products
    // ------------------------------------------------------------------
    logic          s2_valid_reg;
    logic          s2_last_reg;
    logic [PW-1:0] s2_prod1_reg;
    logic [PW-1:0] s2_prod2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            s2_last_reg  <= s1_last_reg;
            s2_prod1_reg <= s1_use1_reg ?
                            PW'(s1_pixel_reg) * PW'(ls_rd_data.above) : '0;
            s2_prod2_reg <= s1_use2_reg ?
                            PW'(s1_pixel_reg) * PW'(ls_rd_data.two_above) : '0;
        end
    end

    // ------------------------------------------------------------------
    // Accumulate with saturation; hand sums off at region end
    // ------------------------------------------------------------------
    logic [SW-1:0] sum1_reg;
    logic [SW-1:0] sum2_reg;
    logic [SW:0]   sum1_wide;
    logic [SW:0]   sum2_wide;
    logic [SW-1:0] sum1_next;
    logic [SW-1:0] sum2_next;
    logic          s3_valid_reg;
    logic [SW-1:0] s3_sum1_reg;
    logic [SW-1:0] s3_sum2_reg;

    always_comb begin
        sum1_wide = {1'b0, sum1_reg} + (SW + 1)'(s2_prod1_reg);
        sum2_wide = {1'b0, sum2_reg} + (SW + 1)'(s2_prod2_reg);
        sum1_next = sum1_wide[SW] ? '1 : sum1_wide[SW-1:0];
        sum2_next = sum2_wide[SW] ? '1 : sum2_wide[SW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum1_reg     <= '0;
            sum2_reg     <= '0;
            s3_valid_reg <= 1'b0;
        end else begin
            s3_valid_reg <= s2_valid_reg && s2_last_reg;
            if (s2_valid_reg) begin
                if (s2_last_reg) begin
                    sum1_reg <= '0;
                    sum2_reg <= '0;
                end else begin
                    sum1_reg <= sum1_next;
                    sum2_reg <= sum2_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_valid_reg && s2_last_reg) begin
            s3_sum1_reg <= sum1_next;
            s3_sum2_reg <= sum2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: difference, saturated to the signed result range
    // ------------------------------------------------------------------
    logic [SW:0]   diff_wide;
    logic [SW-1:0] diff_sat;

    always_comb begin
        diff_wide = {1'b0, s3_sum1_reg} - {1'b0, s3_sum2_reg};
        if (diff_wide[SW] != diff_wide[SW-1]) begin
            diff_sat = {diff_wide[SW], {(SW - 1){~diff_wide[SW]}}};
        end else begin
            diff_sat = diff_wide[SW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    logic [SW-1:0]                  fifo_mem [vff_pkg::FIFO_DEPTH];
    logic [vff_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [vff_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [vff_pkg::FIFO_CNT_W-1:0] count_reg;
    logic [vff_pkg::FIFO_CNT_W-1:0] count_next;
    logic [vff_pkg::FIFO_CNT_W-1:0] pending;
    logic                           push;
    logic                           pop;

    assign push = s3_valid_reg;
    assign pop  = m_valid && m_ready;

    // Push the finished result
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= diff_sat;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + vff_pkg::FIFO_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - vff_pkg::FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + vff_pkg::FIFO_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + vff_pkg::FIFO_PTR_W'(1);
            end
        end
    end

    assign m_valid         = (count_reg != '0);
    assign m_focus_measure = $signed(fifo_mem[rd_ptr_reg]);

    // Hold input while queued plus in-flight results could fill the queue;
    // a word leaving on this edge frees its slot
    assign pending = count_reg
                   + vff_pkg::FIFO_CNT_W'(s1_valid_reg && s1_last_reg)
                   + vff_pkg::FIFO_CNT_W'(s2_valid_reg && s2_last_reg)
                   + vff_pkg::FIFO_CNT_W'(s3_valid_reg);
    assign s_ready = (pending < vff_pkg::FIFO_CNT_W'(vff_pkg::FIFO_DEPTH)) || pop;

endmodule

// ----- sv/vff_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vff_checker
// Port-level checks of the Vollath F4 focus measure, bound to the top level.
// ----------------------------------------------------------------------------
`include "vollath_f4_focus_measure_assert.svh"

module vff_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [vff_pkg::SUM_W-1:0]    m_focus_measure
);

    // A waiting result word holds its value
    `VFF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_focus_measure))

    // No result word right after reset
    `VFF_ASSERT_RESET(a_reset_empty, aclk, !aresetn, !m_valid)

    // Input backpressure only while results are queued
    `VFF_ASSERT_SAME(a_ready_credit, aclk, aresetn, !s_ready, m_valid)

    // A result word appearing in an empty queue comes from an accepted pixel that passed stages 1 to 3
    `VFF_ASSERT_SAME(a_latency, aclk, aresetn, $rose(m_valid), $past(s_valid && s_ready, 4))

endmodule

bind vollath_f4_focus_measure vff_checker u_vff_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_focus_measure (m_focus_measure)
);

// ----- tb/tb_vollath_f4_focus_measure.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vollath_f4_focus_measure
// Self-checking bench for the Vollath F4 focus measure. Streams pixel regions
// of many sizes (tiny, clamped and maximal) through the pixel channel with
// random gaps and output stalls. A line-store tracker rebuilds both lag sums
// per accepted word and queues the F4 value of each finished region. Every
// result word is checked against the oldest queued value.
// ----------------------------------------------------------------------------
module tb_vollath_f4_focus_measure;

    localparam int     PIX_W           = vff_pkg::PIX_W;
    localparam int     SUM_W           = vff_pkg::SUM_W;
    localparam int     CFG_W           = vff_pkg::CFG_W;
    localparam int     CFG_INDEX_W     = vff_pkg::CFG_INDEX_W;
    localparam int     CLK_PERIOD      = 8;
    localparam int     RESET_CYCLES    = 10;
    localparam int     IDLE_PCT        = 12;
    localparam int     PIPE_PAD        = 8;
    localparam int     HOLD_OFF_CYCLES = 300;
    localparam int     RANDOM_ITEMS    = 1830;
    localparam int     MAX_PRINTED     = 40;
    localparam int     MAX_W           = 1024;
    localparam int     MAX_H           = 1024;
    localparam int     F4_SLOTS        = 64;
    localparam int     WIDE_PHASE      = 3;
    localparam int     PRESSURE_PHASE  = 6;
    localparam longint TIMEOUT_CYCLES  = 500000;
    localparam longint SUM_LIMIT       = (longint'(1) <<< SUM_W) - 1;
    localparam longint F4_MAX          = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint F4_MIN          = -(longint'(1) <<< (SUM_W - 1));

    // Tracks line stores, position and lag sums; queues F4 per finished region
    class f4_tracker;
        logic [PIX_W-1:0]        row_above [MAX_W];
        logic [PIX_W-1:0]        row_two_above [MAX_W];
        logic [CFG_W-1:0]        width_reg;
        logic [CFG_W-1:0]        height_reg;
        int unsigned             col;
        int unsigned             row;
        longint                  lag_one;
        longint                  lag_two;
        logic signed [SUM_W-1:0] f4_fifo [F4_SLOTS];
        int unsigned             f4_head;
        int unsigned             f4_tail;
        int unsigned             f4_count;
        int unsigned             mismatches;

        function new();
            foreach (row_above[i]) begin
                row_above[i]     = '0;
                row_two_above[i] = '0;
            end
            width_reg  = vff_pkg::RESET_REGION_WIDTH;
            height_reg = vff_pkg::RESET_REGION_HEIGHT;
            col        = 0;
            row        = 0;
            lag_one    = 0;
            lag_two    = 0;
            f4_head    = 0;
            f4_tail    = 0;
            f4_count   = 0;
            mismatches = 0;
        endfunction

        // Zero acts as one, oversize acts as the maximum
        function int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned limit);
            if (v == 0)
                return 1;
            if (v > limit)
                return limit;
            return v;
        endfunction

        function int unsigned region_pixels();
            return clamp_size(width_reg, MAX_W) * clamp_size(height_reg, MAX_H);
        endfunction

        function int unsigned waiting();
            return f4_count;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                vff_pkg::REG_REGION_WIDTH:  width_reg  = value;
                vff_pkg::REG_REGION_HEIGHT: height_reg = value;
                default: ;
            endcase
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("%0t ERROR %s", $time, what);
        endtask

        // Queue one expected F4 value
        task note_f4(logic signed [SUM_W-1:0] v);
            if (f4_count == F4_SLOTS) begin
                report("expected focus measure queue overflow");
            end else begin
                f4_fifo[f4_tail] = v;
                f4_tail          = (f4_tail + 1) % F4_SLOTS;
                f4_count++;
            end
        endtask

        // Advance by one accepted pixel word
        task take_pixel(logic [PIX_W-1:0] p);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            longint      diff;
            w = clamp_size(width_reg, MAX_W);
            h = clamp_size(height_reg, MAX_H);
            c = col % MAX_W;
            if (row >= 1) begin
                lag_one = lag_one + longint'(p) * longint'(row_above[c]);
                if (lag_one > SUM_LIMIT)
                    lag_one = SUM_LIMIT;
            end
            if (row >= 2) begin
                lag_two = lag_two + longint'(p) * longint'(row_two_above[c]);
                if (lag_two > SUM_LIMIT)
                    lag_two = SUM_LIMIT;
            end
            row_two_above[c] = row_above[c];
            row_above[c]     = p;

            if (col + 1 >= w) begin
                col = 0;
                if (row + 1 >= h) begin
                    diff = lag_one - lag_two;
                    if (diff > F4_MAX)
                        diff = F4_MAX;
                    if (diff < F4_MIN)
                        diff = F4_MIN;
                    note_f4(diff[SUM_W-1:0]);
                    row     = 0;
                    lag_one = 0;
                    lag_two = 0;
                end else begin
                    row++;
                end
            end else begin
                col++;
            end
        endtask

        // Compare a result word with the oldest queued F4 value
        task check_f4(logic signed [SUM_W-1:0] got);
            logic signed [SUM_W-1:0] want;
            if (f4_count == 0) begin
                report($sformatf("focus measure %0d with no region pending", got));
            end else begin
                want     = f4_fifo[f4_head];
                f4_head  = (f4_head + 1) % F4_SLOTS;
                f4_count--;
                if (got !== want)
                    report($sformatf("focus measure %0d, expected %0d", got, want));
            end
        endtask

        task flush_check();
            if (f4_count != 0)
                report($sformatf("%0d focus measures never arrived", f4_count));
        endtask
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [PIX_W-1:0]        s_pixel;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [SUM_W-1:0] m_focus_measure;
    logic                    cfg_wr_en;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]        cfg_wr_data;

    f4_tracker   f4;
    bit          no_idle      = 1'b0;
    bit          hold_off_req = 1'b0;
    bit          dut_held     = 1'b0;
    int unsigned items_sent   = 0;

    vollath_f4_focus_measure #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel         (s_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_focus_measure (m_focus_measure),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data)
    );

    always begin
        #(CLK_PERIOD / 2) aclk = 1'b1;
        #(CLK_PERIOD / 2) aclk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tb_vollath_f4_focus_measure NOT OK");
        $finish;
    end

    // Result side: random stalls, one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req && !dut_held) begin
                dut_held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end
            m_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Check every accepted result word
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            f4.check_f4(m_focus_measure);
    end

    // Write one register; returns after the write edge and updates the tracker
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        f4.set_reg(idx, value);
    endtask

    task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        write_reg(vff_pkg::REG_REGION_WIDTH, w);
        write_reg(vff_pkg::REG_REGION_HEIGHT, h);
    endtask

    // Offer one pixel word after an optional gap, hold until accepted
    task automatic send_pixel(input logic [PIX_W-1:0] p);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= p;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        f4.take_pixel(p);
        items_sent++;
        @(negedge aclk);
    endtask

    // Random pixels for whole regions, extremes weighted up
    task automatic send_regions(input int unsigned regions);
        logic [PIX_W-1:0] p;
        repeat (regions * f4.region_pixels()) begin
            case ($urandom_range(0, 15))
                0:       p = '0;
                1:       p = '1;
                default: p = PIX_W'($urandom_range(0, 255));
            endcase
            send_pixel(p);
        end
    endtask

    // Drop valid, drain results, let the pipeline settle before a new setting
    task automatic finish_phase();
        s_valid <= 1'b0;
        while (f4.waiting() != 0)
            @(negedge aclk);
        repeat (PIPE_PAD) @(negedge aclk);
    endtask

    function automatic logic [CFG_W-1:0] oversize();
        case ($urandom_range(0, 2))
            0:       return 11'd1024;
            1:       return 11'd1025;
            default: return 11'd2047;
        endcase
    endfunction

    initial begin
        int unsigned      phase;
        int unsigned      start_count;
        logic [CFG_W-1:0] w_val;
        logic [CFG_W-1:0] h_val;

        f4          = new();
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_pixel     = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = vff_pkg::REG_REGION_WIDTH;
        cfg_wr_data = '0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // One-row regions of a single pixel give zero
        configure(11'd1, 11'd1);
        send_pixel(8'd0);
        send_pixel(8'd255);
        finish_phase();

        // Two rows: lag-one sum only, at full scale
        configure(11'd2, 11'd2);
        repeat (4) send_pixel(8'd255);
        finish_phase();

        // Zero width acts as one; lag-two term dominates, negative result
        configure(11'd0, 11'd3);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd255);
        finish_phase();

        // Zero height acts as one row
        configure(11'd3, 11'd0);
        send_pixel(8'd1);
        send_pixel(8'd2);
        send_pixel(8'd4);
        finish_phase();

        // Mixed values over four rows
        configure(11'd2, 11'd4);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd128);
        send_pixel(8'd1);
        send_pixel(8'd255);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd127);
        finish_phase();

        // Random phases, each with its own region size
        phase       = 0;
        start_count = items_sent;
        while ((items_sent - start_count) < RANDOM_ITEMS || phase <= PRESSURE_PHASE) begin
            case (phase)
                WIDE_PHASE: begin
                    // Oversize width clamps to the full line, streamed with no gaps
                    no_idle = 1'b1;
                    configure(oversize(), 11'd1);
                    send_regions(1);
                end
                PRESSURE_PHASE: begin
                    // Result every word while the output is held off: input must stall
                    configure(11'd1, 11'd1);
                    hold_off_req = 1'b1;
                    send_regions(40);
                end
                default: begin
                    case ($urandom_range(0, 9))
                        0:       w_val = '0;
                        1:       w_val = CFG_W'($urandom_range(13, 64));
                        default: w_val = CFG_W'($urandom_range(1, 12));
                    endcase
                    case ($urandom_range(0, 9))
                        0:       h_val = '0;
                        1:       h_val = CFG_W'($urandom_range(9, 24));
                        default: h_val = CFG_W'($urandom_range(1, 8));
                    endcase
                    configure(w_val, h_val);
                    send_regions(f4.region_pixels() > 200 ? 1 : $urandom_range(1, 4));
                end
            endcase
            finish_phase();
            no_idle = 1'b0;
            phase++;
        end

        f4.flush_check();
        if (f4.mismatches == 0) begin
            $display("tb_vollath_f4_focus_measure OK");
        end else begin
            $display("tb_vollath_f4_focus_measure NOT OK");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/vff_pkg.sv
sv/vff_line_store.sv
sv/vollath_f4_focus_measure.sv
sv/vff_checker.sv
tb/tb_vollath_f4_focus_measure.sv
